// File: hw/rtl/grid_maze_dfs_solver_defines.svh
// grid_maze_dfs_solver_defines.svh: assertion macros for the maze solver
// used by the top level; no other dependencies

`ifndef GRID_MAZE_DFS_SOLVER_DEFINES_SVH
`define GRID_MAZE_DFS_SOLVER_DEFINES_SVH

// implication that must hold at every clock edge outside reset
`define GMDS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// condition that must never be seen outside reset
`define GMDS_NEVER(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

// File: hw/rtl/gmds_pkg.sv
// gmds_pkg: types, codes and helper functions of the maze solver
// no dependencies; imported by gmds_ctrl, gmds_dpath and the top level

package gmds_pkg;

   localparam int MAX_ROWS_DEF = 64;
   localparam int MAX_COLS_DEF = 64;
   localparam int COORD_W      = 7;
   localparam int DIM_W        = 11;
   localparam int IDX_W        = 12;
   localparam int LEN_W        = 13;
   localparam int CSR_IDX_W    = 3;
   localparam int DIR_W        = 3;
   localparam int TRY_W        = 4;
   localparam int NUM_DIRS     = 8;
   localparam int STK_W        = 2 * COORD_W + DIR_W;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_SOLVE = 2'd1,
      CMD_READ  = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   localparam logic [1:0] STS_OK     = 2'd0;
   localparam logic [1:0] STS_NOPATH = 2'd1;
   localparam logic [1:0] STS_RANGE  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_COUNT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_ROW = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_START_COL = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GOAL_ROW  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GOAL_COL  = 3'd5;

   localparam logic [DIR_W-1:0] DIR_N = 3'd0;
   localparam logic [DIR_W-1:0] DIR_E = 3'd2;
   localparam logic [DIR_W-1:0] DIR_S = 3'd4;
   localparam logic [DIR_W-1:0] DIR_W_ = 3'd6;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_CLEAR,
      OP_INIT,
      OP_FAIL,
      OP_POP,
      OP_LOAD,
      OP_TURN,
      OP_ENTER,
      OP_GOAL,
      OP_RDATA
   } op_type;

   typedef struct packed {
      op_type op;
      logic   out_load;
   } ctl_type;

   typedef struct packed {
      logic clr_last;
      logic ends_ok;
      logic stack_empty;
      logic stack_full;
      logic tries_done;
      logic goal_hit;
      logic in_grid;
      logic cell_free;
   } sts_type;

   typedef struct packed {
      logic [DIR_W-1:0] dir;
      logic             ccw;
   } head_type;

   // row step per direction, sign-extended to 8 bits
   function automatic logic [7:0] step_row(input logic [DIR_W-1:0] d);
      logic [7:0] s;
      case (d)
         3'd0, 3'd1, 3'd7: s = 8'hFF;
         3'd3, 3'd4, 3'd5: s = 8'h01;
         default:          s = 8'h00;
      endcase
      return s;
   endfunction

   function automatic logic [7:0] step_col(input logic [DIR_W-1:0] d);
      logic [7:0] s;
      case (d)
         3'd1, 3'd2, 3'd3: s = 8'h01;
         3'd5, 3'd6, 3'd7: s = 8'hFF;
         default:          s = 8'h00;
      endcase
      return s;
   endfunction

   // first direction and turn sense of a cell, from the goal offset
   function automatic head_type first_dir(input logic [7:0] r, input logic [7:0] c,
                                          input logic [7:0] gr, input logic [7:0] gc);
      head_type h;
      h.ccw = 1'b0;
      if (gc > c) begin
         h.dir = DIR_E;
         h.ccw = (gr < r);
      end else if (gc < c) begin
         h.dir = DIR_W_;
         h.ccw = (gr > r);
      end else begin
         h.dir = (gr > r) ? DIR_S : DIR_N;
      end
      return h;
   endfunction

endpackage

// File: hw/rtl/gmds_ram.sv
// gmds_ram: generic simple dual-port ram, registered read
// no dependencies

module gmds_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// File: hw/rtl/gmds_ctrl.sv
// gmds_ctrl: sequencer of the maze solver (intake, clear sweep, search, readback)
// depends on gmds_pkg

module gmds_ctrl
   import gmds_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_command,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  sts_type    sts,
   output ctl_type    ctl
);

   typedef enum logic [3:0] {
      S_IDLE, S_CLEAR, S_INIT, S_POP, S_LOAD, S_TRY, S_CHECK, S_RADDR, S_RDATA
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      ctl.op       = OP_NONE;
      ctl.out_load = 1'b0;
      req_ready    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = !rsp_valid_ff || rsp_ready;
            if (req_valid && req_ready) begin
               ctl.op = OP_ACCEPT;
               case (cmd_type'(req_command))
                  CMD_SOLVE: state_in = S_CLEAR;
                  CMD_READ:  state_in = S_RADDR;
                  default:   ctl.out_load = 1'b1;
               endcase
            end
         end
         S_CLEAR: begin
            ctl.op = OP_CLEAR;
            if (sts.clr_last) begin
               state_in = S_INIT;
            end
         end
         S_INIT: begin
            if (sts.ends_ok) begin
               ctl.op   = OP_INIT;
               state_in = S_POP;
            end else begin
               ctl.op       = OP_FAIL;
               ctl.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_POP: begin
            if (sts.stack_empty) begin
               ctl.op       = OP_FAIL;
               ctl.out_load = 1'b1;
               state_in     = S_IDLE;
            end else begin
               ctl.op   = OP_POP;
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            ctl.op   = OP_LOAD;
            state_in = S_TRY;
         end
         S_TRY: begin
            if (sts.tries_done) begin
               state_in = S_POP;
            end else if (sts.goal_hit) begin
               ctl.op       = sts.stack_full ? OP_FAIL : OP_GOAL;
               ctl.out_load = 1'b1;
               state_in     = S_IDLE;
            end else if (sts.in_grid) begin
               state_in = S_CHECK;
            end else begin
               ctl.op = OP_TURN;
            end
         end
         S_CHECK: begin
            state_in = S_TRY;
            if (!sts.cell_free) begin
               ctl.op = OP_TURN;
            end else if (sts.stack_full) begin
               ctl.op       = OP_FAIL;
               ctl.out_load = 1'b1;
               state_in     = S_IDLE;
            end else begin
               ctl.op = OP_ENTER;
            end
         end
         S_RADDR: begin
            state_in = S_RDATA;
         end
         S_RDATA: begin
            ctl.op       = OP_RDATA;
            ctl.out_load = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_valid_in = ctl.out_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: hw/rtl/gmds_dpath.sv
// gmds_dpath: maze solver datapath (settings, maps, stack, cursor, result register)
// depends on gmds_pkg and gmds_ram

module gmds_dpath
   import gmds_pkg::*;
#(
   parameter int MAX_ROWS = MAX_ROWS_DEF,
   parameter int MAX_COLS = MAX_COLS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COORD_W-1:0]   csr_wdata,
   input  logic [1:0]           req_command,
   input  logic [COORD_W-1:0]   req_cell_row,
   input  logic [COORD_W-1:0]   req_cell_col,
   input  logic                 req_cell_open,
   input  logic [IDX_W-1:0]     req_path_index,
   output logic [1:0]           rsp_status,
   output logic                 rsp_found,
   output logic [LEN_W-1:0]     rsp_path_length,
   output logic [COORD_W-1:0]   rsp_out_row,
   output logic [COORD_W-1:0]   rsp_out_col,
   input  ctl_type              ctl,
   output sts_type              sts
);

   localparam int CELLS  = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int TOP_W  = $clog2(CELLS + 1);

   // settings
   logic [COORD_W-1:0] row_count_ff, col_count_ff, start_row_ff, start_col_ff;
   logic [COORD_W-1:0] goal_row_ff, goal_col_ff;

   // search state
   logic [COORD_W-1:0] i_ff, j_ff;
   logic [DIR_W-1:0]   d_ff;
   logic [TRY_W-1:0]   tries_ff;
   logic               ccw_ff;
   logic [TOP_W-1:0]   top_ff;
   logic               found_ff;
   logic [ADDR_W-1:0]  clr_ff;
   logic [IDX_W-1:0]   idx_ff;

   logic [DIM_W-1:0]   nr, nc;
   logic [7:0]         v, h, gr8, gc8;
   logic [DIR_W-1:0]   dn;
   head_type           fd_start, fd_probe;
   logic [31:0]        probe_lin, start_lin, cell_lin;
   logic [ADDR_W-1:0]  probe_addr, start_addr, cell_addr;
   logic               cell_wr;

   logic               open_rd, vis_rd;
   logic               vis_we, vis_wd, stk_we;
   logic [ADDR_W-1:0]  vis_wa, stk_wa, stk_ra;
   logic [STK_W-1:0]   stk_wd, stk_rd;
   logic [COORD_W-1:0] rd_row, rd_col;
   logic [DIR_W-1:0]   rd_dir;

   // settings port
   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= 7'd64;
         col_count_ff <= 7'd64;
         start_row_ff <= 7'd1;
         start_col_ff <= 7'd1;
         goal_row_ff  <= 7'd64;
         goal_col_ff  <= 7'd64;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_ROW_COUNT: row_count_ff <= csr_wdata;
            CSR_COL_COUNT: col_count_ff <= csr_wdata;
            CSR_START_ROW: start_row_ff <= csr_wdata;
            CSR_START_COL: start_col_ff <= csr_wdata;
            CSR_GOAL_ROW:  goal_row_ff  <= csr_wdata;
            CSR_GOAL_COL:  goal_col_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // grid size clamped into 1..max
   always_comb begin
      nr = DIM_W'(row_count_ff);
      if (row_count_ff == '0) begin
         nr = DIM_W'(1);
      end else if (32'(row_count_ff) > 32'(MAX_ROWS)) begin
         nr = DIM_W'(MAX_ROWS);
      end
      nc = DIM_W'(col_count_ff);
      if (col_count_ff == '0) begin
         nc = DIM_W'(1);
      end else if (32'(col_count_ff) > 32'(MAX_COLS)) begin
         nc = DIM_W'(MAX_COLS);
      end
   end

   // neighbor under test
   assign gr8 = {1'b0, goal_row_ff};
   assign gc8 = {1'b0, goal_col_ff};
   assign v   = {1'b0, i_ff} + step_row(d_ff);
   assign h   = {1'b0, j_ff} + step_col(d_ff);
   assign dn  = ccw_ff ? d_ff - 3'd1 : d_ff + 3'd1;

   assign fd_start = first_dir({1'b0, start_row_ff}, {1'b0, start_col_ff}, gr8, gc8);
   assign fd_probe = first_dir(v, h, gr8, gc8);

   assign probe_lin  = 32'(v - 8'd1) * 32'(MAX_COLS) + 32'(h - 8'd1);
   assign start_lin  = 32'(start_row_ff - 7'd1) * 32'(MAX_COLS) + 32'(start_col_ff - 7'd1);
   assign cell_lin   = 32'(req_cell_row - 7'd1) * 32'(MAX_COLS) + 32'(req_cell_col - 7'd1);
   assign probe_addr = probe_lin[ADDR_W-1:0];
   assign start_addr = start_lin[ADDR_W-1:0];
   assign cell_addr  = cell_lin[ADDR_W-1:0];

   assign cell_wr = (ctl.op == OP_ACCEPT) && (cmd_type'(req_command) == CMD_WRITE)
                    && (req_cell_row != '0) && (32'(req_cell_row) <= 32'(MAX_ROWS))
                    && (req_cell_col != '0) && (32'(req_cell_col) <= 32'(MAX_COLS));

   // status to the sequencer
   always_comb begin
      sts.clr_last    = (clr_ff == ADDR_W'(CELLS - 1));
      sts.ends_ok     = (start_row_ff != '0) && (DIM_W'(start_row_ff) <= nr)
                        && (start_col_ff != '0) && (DIM_W'(start_col_ff) <= nc)
                        && (goal_row_ff != '0) && (DIM_W'(goal_row_ff) <= nr)
                        && (goal_col_ff != '0) && (DIM_W'(goal_col_ff) <= nc);
      sts.stack_empty = (top_ff == '0);
      sts.stack_full  = (top_ff >= TOP_W'(CELLS));
      sts.tries_done  = (tries_ff == TRY_W'(NUM_DIRS));
      sts.goal_hit    = (v == gr8) && (h == gc8);
      sts.in_grid     = (v != '0) && (DIM_W'(v) <= nr) && (h != '0) && (DIM_W'(h) <= nc);
      sts.cell_free   = open_rd && !vis_rd;
   end

   // memory ports
   always_comb begin
      vis_we = 1'b0;
      vis_wa = probe_addr;
      vis_wd = 1'b1;
      stk_we = 1'b0;
      stk_wa = ADDR_W'(top_ff);
      stk_wd = {i_ff, j_ff, d_ff};
      case (ctl.op)
         OP_CLEAR: begin
            vis_we = 1'b1;
            vis_wa = clr_ff;
            vis_wd = 1'b0;
         end
         OP_INIT: begin
            // the start cell always goes to the bottom of the stack
            vis_we = 1'b1;
            vis_wa = start_addr;
            stk_we = 1'b1;
            stk_wa = '0;
            stk_wd = {start_row_ff, start_col_ff, fd_start.dir};
         end
         OP_ENTER: begin
            vis_we = 1'b1;
            stk_we = 1'b1;
            stk_wd = {i_ff, j_ff, dn};
         end
         OP_GOAL: begin
            stk_we = 1'b1;
         end
         default: ;
      endcase
      stk_ra = (ctl.op == OP_POP) ? ADDR_W'(top_ff - TOP_W'(1)) : ADDR_W'(idx_ff);
   end

   gmds_ram #(.WIDTH(1), .DEPTH(CELLS), .ADDR_W(ADDR_W)) u_open_map (
      .clock   (clock),
      .wr_en   (cell_wr),
      .wr_addr (cell_addr),
      .wr_data (req_cell_open),
      .rd_addr (probe_addr),
      .rd_data (open_rd)
   );

   gmds_ram #(.WIDTH(1), .DEPTH(CELLS), .ADDR_W(ADDR_W)) u_visited_map (
      .clock   (clock),
      .wr_en   (vis_we),
      .wr_addr (vis_wa),
      .wr_data (vis_wd),
      .rd_addr (probe_addr),
      .rd_data (vis_rd)
   );

   gmds_ram #(.WIDTH(STK_W), .DEPTH(CELLS), .ADDR_W(ADDR_W)) u_stack (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_wa),
      .wr_data (stk_wd),
      .rd_addr (stk_ra),
      .rd_data (stk_rd)
   );

   assign {rd_row, rd_col, rd_dir} = stk_rd;

   // search state
   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff   <= '0;
         found_ff <= 1'b0;
         ccw_ff   <= 1'b0;
      end else begin
         case (ctl.op)
            OP_INIT: begin
               top_ff   <= TOP_W'(1);
               found_ff <= 1'b0;
               ccw_ff   <= fd_start.ccw;
            end
            OP_FAIL: begin
               top_ff   <= '0;
               found_ff <= 1'b0;
            end
            OP_POP:   top_ff <= top_ff - TOP_W'(1);
            OP_ENTER: begin
               top_ff <= top_ff + TOP_W'(1);
               ccw_ff <= fd_probe.ccw;
            end
            OP_GOAL: begin
               top_ff   <= top_ff + TOP_W'(1);
               found_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (ctl.op)
         OP_ACCEPT: begin
            idx_ff <= req_path_index;
            clr_ff <= '0;
         end
         OP_CLEAR: clr_ff <= clr_ff + ADDR_W'(1);
         OP_LOAD: begin
            i_ff     <= rd_row;
            j_ff     <= rd_col;
            d_ff     <= rd_dir;
            tries_ff <= '0;
         end
         OP_TURN: begin
            d_ff     <= dn;
            tries_ff <= tries_ff + TRY_W'(1);
         end
         OP_ENTER: begin
            i_ff     <= v[COORD_W-1:0];
            j_ff     <= h[COORD_W-1:0];
            d_ff     <= fd_probe.dir;
            tries_ff <= '0;
         end
         default: ;
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (ctl.out_load) begin
         rsp_out_row <= '0;
         rsp_out_col <= '0;
         case (ctl.op)
            OP_FAIL: begin
               rsp_status      <= STS_NOPATH;
               rsp_found       <= 1'b0;
               rsp_path_length <= '0;
            end
            OP_GOAL: begin
               rsp_status      <= STS_OK;
               rsp_found       <= 1'b1;
               rsp_path_length <= LEN_W'(top_ff + TOP_W'(1));
            end
            OP_RDATA: begin
               rsp_found       <= found_ff;
               rsp_path_length <= found_ff ? LEN_W'(top_ff) : '0;
               if (!found_ff) begin
                  rsp_status <= STS_NOPATH;
               end else if (32'(idx_ff) >= 32'(top_ff)) begin
                  rsp_status <= STS_RANGE;
               end else begin
                  rsp_status  <= STS_OK;
                  rsp_out_row <= rd_row;
                  rsp_out_col <= rd_col;
               end
            end
            default: begin
               rsp_status      <= STS_OK;
               rsp_found       <= found_ff;
               rsp_path_length <= found_ff ? LEN_W'(top_ff) : '0;
            end
         endcase
      end
   end

endmodule

// File: hw/rtl/grid_maze_dfs_solver.sv
// grid_maze_dfs_solver: top level of the depth-first maze solver
// depends on gmds_pkg, gmds_ctrl, gmds_dpath, gmds_ram and the defines header
//
//   channel   ports            moves
//   request   req_valid/ready  command, cell_row, cell_col, cell_open, path_index
//   response  rsp_valid/ready  status, found, path_length, out_row, out_col
//   settings  csr_write_enable register index and value, no handshake
//
// a cell write or an unused command answers in the cycle after it is taken; a path
// read passes S_RADDR and S_RDATA (one stack ram read with registered output)
// a solve first sweeps the whole visited map, then seeds the start cell, pops
// and loads stack entries, turns past blocked directions and probes each cell
// reset is synchronous and active high; maps and stack need none
// intake stays closed while a solve or read runs and while a result waits
// with rsp_ready low

`include "grid_maze_dfs_solver_defines.svh"

module grid_maze_dfs_solver
   import gmds_pkg::*;
#(
   parameter int MAX_ROWS = MAX_ROWS_DEF,
   parameter int MAX_COLS = MAX_COLS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   // settings
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COORD_W-1:0]   csr_wdata,
   // request
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_command,
   input  logic [COORD_W-1:0]   req_cell_row,
   input  logic [COORD_W-1:0]   req_cell_col,
   input  logic                 req_cell_open,
   input  logic [IDX_W-1:0]     req_path_index,
   // response
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_status,
   output logic                 rsp_found,
   output logic [LEN_W-1:0]     rsp_path_length,
   output logic [COORD_W-1:0]   rsp_out_row,
   output logic [COORD_W-1:0]   rsp_out_col
);

   ctl_type ctl;
   sts_type sts;

   // sequencer: owns the handshake and walks the search steps
   gmds_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .sts         (sts),
      .ctl         (ctl)
   );

   // datapath: settings, open and visited maps, path stack, result register
   gmds_dpath #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_command      (req_command),
      .req_cell_row     (req_cell_row),
      .req_cell_col     (req_cell_col),
      .req_cell_open    (req_cell_open),
      .req_path_index   (req_path_index),
      .rsp_status       (rsp_status),
      .rsp_found        (rsp_found),
      .rsp_path_length  (rsp_path_length),
      .rsp_out_row      (rsp_out_row),
      .rsp_out_col      (rsp_out_col),
      .ctl              (ctl),
      .sts              (sts)
   );

   // a transfer in is only taken when the result register is free or freeing
   `GMDS_ASSERT(a_intake_room, req_valid && req_ready |-> !rsp_valid || rsp_ready, "intake with result stuck")
   // a solve closes intake on the next cycle
   `GMDS_ASSERT(a_solve_busy, req_valid && req_ready && req_command == CMD_SOLVE |=> !req_ready, "intake open during solve")
   // no path means no length
   `GMDS_NEVER(a_len_without_path, rsp_valid && !rsp_found && rsp_path_length != '0, "path length without path")
   // a found path never reports no path
   `GMDS_NEVER(a_found_status, rsp_valid && rsp_found && rsp_status == STS_NOPATH, "found with no-path status")

endmodule
